@@ sv/lfpd_pkg.sv @@
// shared types, constants and the microcode program of the line follower pid drive
// no dependencies; imported by lfpd_seq, line_follow_pid_drive_unit, lfpd_drive_check and the bench
package lfpd_pkg;

   // fixed geometry and number formats
   localparam int SENSOR_COUNT   = 10;
   localparam int SENSOR_HALF    = SENSOR_COUNT / 2;
   localparam int FRAC_BITS      = 8;
   localparam int GAIN_FRAC_BITS = 4;
   localparam int SUM_SHIFT      = FRAC_BITS + GAIN_FRAC_BITS;
   localparam int MID_WEIGHT     = SENSOR_COUNT + 1;
   localparam int SEARCH_LO      = 2;
   localparam int SEARCH_HI      = 7;
   localparam int RECOVER_COUNT  = 2;

   localparam int ERR_W    = 12;
   localparam int GAIN_W   = 10;
   localparam int LIMIT_W  = 11;
   localparam int SPEED_W  = 8;
   localparam int THRESH_W = 12;
   localparam int INTEG_W  = 16;
   localparam int DIFF_W   = ERR_W + 1;
   localparam int MUL_A_W  = GAIN_W + 1;
   localparam int MUL_B_W  = INTEG_W + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ACC_W    = 28;
   localparam int WHEEL_W  = 30;
   localparam int DUTY_W   = 8;
   localparam int DRIVE_W  = DUTY_W + 1;
   localparam int DIV_W    = 12;
   localparam int CNT_W    = 4;
   localparam int WSUM_W   = 6;
   localparam int NUM_W    = 8;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 12;

   // 1.2 scale as a reciprocal multiply, exact for magnitudes up to 255
   localparam int SCALE_MUL   = 1229;
   localparam int SCALE_SHIFT = 10;
   localparam int SCALE_W     = 11;
   localparam int DUTY_MAX    = 255;

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = 16'sh7FFF;
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = 16'sh8000;
   localparam logic signed [ERR_W-1:0]   ERR_MAX   = 12'sd1152;

   // register reset values
   localparam logic [GAIN_W-1:0]   KP_RESET    = 10'd56;
   localparam logic [GAIN_W-1:0]   KI_RESET    = 10'd8;
   localparam logic [GAIN_W-1:0]   KD_RESET    = 10'd32;
   localparam logic [LIMIT_W-1:0]  LOST_RESET  = 11'd896;
   localparam logic [SPEED_W-1:0]  BASE_RESET  = 8'd40;
   localparam logic [SPEED_W-1:0]  LIMIT_RESET = 8'd180;
   localparam logic [THRESH_W-1:0] EDGE_RESET  = 12'd90;
   localparam logic [THRESH_W-1:0] INNER_RESET = 12'd80;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KP       = 4'd0,
      REG_KI       = 4'd1,
      REG_KD       = 4'd2,
      REG_LOST     = 4'd3,
      REG_BASE     = 4'd4,
      REG_LIMIT    = 4'd5,
      REG_EDGE_TH  = 4'd6,
      REG_INNER_TH = 4'd7
   } csr_reg_type;

   typedef enum logic [3:0] {
      ACT_IDLE    = 4'd0,
      ACT_SETUP   = 4'd1,
      ACT_DIV     = 4'd2,
      ACT_ERR     = 4'd3,
      ACT_INTEG   = 4'd4,
      ACT_NONE    = 4'd5,
      ACT_CLAMP_L = 4'd6,
      ACT_SCALE_L = 4'd7,
      ACT_CLAMP_R = 4'd8,
      ACT_SCALE_R = 4'd9,
      ACT_LOST    = 4'd10,
      ACT_SEARCH  = 4'd11,
      ACT_FINISH  = 4'd12
   } act_type;

   typedef enum logic [1:0] {
      MUL_NONE     = 2'd0,
      MUL_KP_ERR   = 2'd1,
      MUL_KD_DIFF  = 2'd2,
      MUL_KI_INTEG = 2'd3
   } mul_type;

   typedef enum logic [1:0] {
      ACC_HOLD  = 2'd0,
      ACC_CLEAR = 2'd1,
      ACC_ADD   = 2'd2
   } acc_type;

   typedef enum logic [2:0] {
      JMP_NEXT        = 3'd0,
      JMP_WAIT_GO     = 3'd1,
      JMP_IF_SEARCH   = 3'd2,
      JMP_DIV_LOOP    = 3'd3,
      JMP_ALWAYS      = 3'd4,
      JMP_IF_OUT_FREE = 3'd5
   } jmp_type;

   typedef logic [3:0] step_type;

   localparam step_type ST_IDLE    = 4'd0;
   localparam step_type ST_SETUP   = 4'd1;
   localparam step_type ST_DIV     = 4'd2;
   localparam step_type ST_ERR     = 4'd3;
   localparam step_type ST_INTEG   = 4'd4;
   localparam step_type ST_MUL_KP  = 4'd5;
   localparam step_type ST_MUL_KD  = 4'd6;
   localparam step_type ST_MUL_KI  = 4'd7;
   localparam step_type ST_ACC_KI  = 4'd8;
   localparam step_type ST_CLAMP_L = 4'd9;
   localparam step_type ST_SCALE_L = 4'd10;
   localparam step_type ST_CLAMP_R = 4'd11;
   localparam step_type ST_SCALE_R = 4'd12;
   localparam step_type ST_LOST    = 4'd13;
   localparam step_type ST_SEARCH  = 4'd14;
   localparam step_type ST_FINISH  = 4'd15;

   typedef struct packed {
      act_type  act;
      mul_type  mul;
      acc_type  acc;
      jmp_type  jmp;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic go;
      logic search;
      logic div_last;
      logic out_free;
   } status_type;

   // the control program, one word per step
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      case (step)
         ST_IDLE:    w = '{ACT_IDLE,    MUL_NONE,     ACC_HOLD,  JMP_WAIT_GO,     ST_IDLE};
         ST_SETUP:   w = '{ACT_SETUP,   MUL_NONE,     ACC_HOLD,  JMP_IF_SEARCH,   ST_SEARCH};
         ST_DIV:     w = '{ACT_DIV,     MUL_NONE,     ACC_HOLD,  JMP_DIV_LOOP,    ST_DIV};
         ST_ERR:     w = '{ACT_ERR,     MUL_NONE,     ACC_HOLD,  JMP_NEXT,        ST_IDLE};
         ST_INTEG:   w = '{ACT_INTEG,   MUL_NONE,     ACC_HOLD,  JMP_NEXT,        ST_IDLE};
         ST_MUL_KP:  w = '{ACT_NONE,    MUL_KP_ERR,   ACC_CLEAR, JMP_NEXT,        ST_IDLE};
         ST_MUL_KD:  w = '{ACT_NONE,    MUL_KD_DIFF,  ACC_ADD,   JMP_NEXT,        ST_IDLE};
         ST_MUL_KI:  w = '{ACT_NONE,    MUL_KI_INTEG, ACC_ADD,   JMP_NEXT,        ST_IDLE};
         ST_ACC_KI:  w = '{ACT_NONE,    MUL_NONE,     ACC_ADD,   JMP_NEXT,        ST_IDLE};
         ST_CLAMP_L: w = '{ACT_CLAMP_L, MUL_NONE,     ACC_HOLD,  JMP_NEXT,        ST_IDLE};
         ST_SCALE_L: w = '{ACT_SCALE_L, MUL_NONE,     ACC_HOLD,  JMP_NEXT,        ST_IDLE};
         ST_CLAMP_R: w = '{ACT_CLAMP_R, MUL_NONE,     ACC_HOLD,  JMP_NEXT,        ST_IDLE};
         ST_SCALE_R: w = '{ACT_SCALE_R, MUL_NONE,     ACC_HOLD,  JMP_NEXT,        ST_IDLE};
         ST_LOST:    w = '{ACT_LOST,    MUL_NONE,     ACC_HOLD,  JMP_ALWAYS,      ST_FINISH};
         ST_SEARCH:  w = '{ACT_SEARCH,  MUL_NONE,     ACC_HOLD,  JMP_NEXT,        ST_IDLE};
         ST_FINISH:  w = '{ACT_FINISH,  MUL_NONE,     ACC_HOLD,  JMP_IF_OUT_FREE, ST_IDLE};
         default:    w = '{ACT_IDLE,    MUL_NONE,     ACC_HOLD,  JMP_ALWAYS,      ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ sv/lfpd_seq.sv @@
// microcode sequencer: step counter, program table lookup and conditional jumps
// depends on lfpd_pkg for the control word, status and program
module lfpd_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  lfpd_pkg::status_type    status,
   output lfpd_pkg::ctrl_word_type ctrl
);
   import lfpd_pkg::*;

   step_type step_ff;
   step_type step_in;
   step_type step_inc;

   assign ctrl     = ucode_rom(step_ff);
   assign step_inc = step_type'(step_ff + 1'b1);

   always_comb begin
      case (ctrl.jmp)
         JMP_WAIT_GO:     step_in = status.go ? step_inc : step_ff;
         JMP_IF_SEARCH:   step_in = status.search ? ctrl.target : step_inc;
         JMP_DIV_LOOP:    step_in = status.div_last ? step_inc : step_ff;
         JMP_ALWAYS:      step_in = ctrl.target;
         JMP_IF_OUT_FREE: step_in = status.out_free ? ctrl.target : step_ff;
         default:         step_in = step_inc;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ sv/line_follow_pid_drive_unit.sv @@
// top level of the line follower pid drive: handshakes, registers and datapath
// depends on lfpd_pkg and lfpd_seq
//
// One request beat carries ten reflectance samples; each is thresholded (edge
// threshold for sensors 0 and 9, inner threshold for the rest) into a sensor
// pattern, the weighted line position minus 5.5 gives a Q8 error (zero with no
// line), and a PID correction with Q4 gains is added to the base speed for the
// left wheel and subtracted for the right. Each side is clamped to the speed
// limit, scaled by 1.2 toward zero and sent as an 8-bit duty plus a reverse
// bit. When the error magnitude reaches lost_limit the drive is held and later
// frames only look for two or more of sensors 2..7 on the line. A microcoded
// sequencer steps one shared datapath through the frame: the length of a
// driving frame is set mostly by the 12-step restoring divider for the
// position and the single multiplier used three times for the PID terms; a
// frame during the hold skips both the divider and the multiplier. The result
// sits in an output register, so a new frame is taken while a result beat
// waits, and the program only stalls at its last step if that register is
// still full. Configuration writes are always ready and should be made while
// no frame is in flight.
module line_follow_pid_drive_unit #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [SAMPLE_BITS-1:0]               req_sample_0,
   input  logic [SAMPLE_BITS-1:0]               req_sample_1,
   input  logic [SAMPLE_BITS-1:0]               req_sample_2,
   input  logic [SAMPLE_BITS-1:0]               req_sample_3,
   input  logic [SAMPLE_BITS-1:0]               req_sample_4,
   input  logic [SAMPLE_BITS-1:0]               req_sample_5,
   input  logic [SAMPLE_BITS-1:0]               req_sample_6,
   input  logic [SAMPLE_BITS-1:0]               req_sample_7,
   input  logic [SAMPLE_BITS-1:0]               req_sample_8,
   input  logic [SAMPLE_BITS-1:0]               req_sample_9,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lfpd_pkg::DUTY_W-1:0]          rsp_left_duty,
   output logic                                 rsp_left_reverse,
   output logic [lfpd_pkg::DUTY_W-1:0]          rsp_right_duty,
   output logic                                 rsp_right_reverse,
   output logic signed [lfpd_pkg::ERR_W-1:0]    rsp_line_error,
   output logic [lfpd_pkg::SENSOR_COUNT-1:0]    rsp_sensor_pattern,
   output logic                                 rsp_searching,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lfpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import lfpd_pkg::*;

   localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

   // sequencer link
   ctrl_word_type ctrl;
   status_type    status;
   logic          go;
   logic          out_free;

   // configuration registers
   logic [GAIN_W-1:0]   kp_ff, kp_in;
   logic [GAIN_W-1:0]   ki_ff, ki_in;
   logic [GAIN_W-1:0]   kd_ff, kd_in;
   logic [LIMIT_W-1:0]  lost_ff, lost_in;
   logic [SPEED_W-1:0]  base_ff, base_in;
   logic [SPEED_W-1:0]  limit_ff, limit_in;
   logic [THRESH_W-1:0] edge_th_ff, edge_th_in;
   logic [THRESH_W-1:0] inner_th_ff, inner_th_in;

   // frame capture
   logic [SAMPLE_BITS-1:0]  sample_arr [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0] hit;
   logic [SENSOR_COUNT-1:0] pattern_ff, pattern_in;

   // position and divider
   logic [WSUM_W-1:0] w_lo, w_hi, w_sum;
   logic [CNT_W-1:0]  t_cnt;
   logic [NUM_W-1:0]  two_w, mid_t, n_mag;
   logic              n_neg;
   logic [CNT_W-1:0]  tcnt_ff, tcnt_in;
   logic              neg_ff, neg_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [CNT_W:0]    r_try;

   // pid state and terms
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   prev_ff, prev_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [INTEG_W:0]   isum;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   // wheel shaping
   logic signed [WHEEL_W-1:0] base_ext, acc_ext, wheel_x, wheel_r, wheel_v, lim_ext;
   logic [DUTY_W-1:0]         wmag_ff, wmag_in;
   logic                      wneg_ff, wneg_in;
   logic [DUTY_W+SCALE_W-1:0] scale_prod;
   logic [DRIVE_W-1:0]        scaled;
   logic [DUTY_W-1:0]         duty;
   logic [DRIVE_W-1:0]        ldrive_ff, ldrive_in;
   logic [DRIVE_W-1:0]        rdrive_ff, rdrive_in;
   logic [2*DRIVE_W-1:0]      held_ff, held_in;
   logic                      search_ff, search_in;
   logic                      srch_out_ff, srch_out_in;
   logic [ERR_W-1:0]          err_mag;
   logic [CNT_W-1:0]          recover_cnt;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]        rsp_ldrive_ff, rsp_ldrive_in;
   logic [DRIVE_W-1:0]        rsp_rdrive_ff, rsp_rdrive_in;
   logic signed [ERR_W-1:0]   rsp_err_ff, rsp_err_in;
   logic [SENSOR_COUNT-1:0]   rsp_pattern_ff, rsp_pattern_in;
   logic                      rsp_srch_ff, rsp_srch_in;

   lfpd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // handshakes: a frame is taken only while the program sits at its idle step
   assign req_stall = (ctrl.act != ACT_IDLE);
   assign go        = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign status.go       = go;
   assign status.search   = search_ff;
   assign status.div_last = (div_cnt_ff == CNT_W'(1));
   assign status.out_free = out_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_duty      = rsp_ldrive_ff[DUTY_W-1:0];
   assign rsp_left_reverse   = rsp_ldrive_ff[DUTY_W];
   assign rsp_right_duty     = rsp_rdrive_ff[DUTY_W-1:0];
   assign rsp_right_reverse  = rsp_rdrive_ff[DUTY_W];
   assign rsp_line_error     = rsp_err_ff;
   assign rsp_sensor_pattern = rsp_pattern_ff;
   assign rsp_searching      = rsp_srch_ff;

   // sample thresholds, one compare per sensor
   assign sample_arr[0] = req_sample_0;
   assign sample_arr[1] = req_sample_1;
   assign sample_arr[2] = req_sample_2;
   assign sample_arr[3] = req_sample_3;
   assign sample_arr[4] = req_sample_4;
   assign sample_arr[5] = req_sample_5;
   assign sample_arr[6] = req_sample_6;
   assign sample_arr[7] = req_sample_7;
   assign sample_arr[8] = req_sample_8;
   assign sample_arr[9] = req_sample_9;

   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (i == 0 || i == SENSOR_COUNT - 1) begin
            hit[i] = CMP_W'(sample_arr[i]) >= CMP_W'(edge_th_ff);
         end else begin
            hit[i] = CMP_W'(sample_arr[i]) >= CMP_W'(inner_th_ff);
         end
      end
   end

   // weighted sum in two halves, weights count from one
   always_comb begin
      w_lo = '0;
      w_hi = '0;
      for (int i = 0; i < SENSOR_HALF; i++) begin
         if (pattern_ff[i]) begin
            w_lo = w_lo + WSUM_W'(i + 1);
         end
      end
      for (int i = SENSOR_HALF; i < SENSOR_COUNT; i++) begin
         if (pattern_ff[i]) begin
            w_hi = w_hi + WSUM_W'(i + 1);
         end
      end
   end

   assign w_sum = w_lo + w_hi;
   assign t_cnt = CNT_W'($countones(pattern_ff));
   assign two_w = {1'b0, w_sum, 1'b0};
   assign mid_t = NUM_W'(t_cnt * MID_WEIGHT);
   assign n_neg = (two_w < mid_t);
   assign n_mag = n_neg ? (mid_t - two_w) : (two_w - mid_t);

   // restoring divider trial subtract
   assign r_try = {rem_ff, num_ff[DIV_W-1]};

   // integral update and derivative
   assign isum = $signed({integ_ff[INTEG_W-1], integ_ff})
               + $signed({{(INTEG_W + 1 - ERR_W){err_ff[ERR_W-1]}}, err_ff});

   // shared multiplier operands
   always_comb begin
      case (ctrl.mul)
         MUL_KP_ERR: begin
            mul_a = $signed({1'b0, kp_ff});
            mul_b = MUL_B_W'(err_ff);
         end
         MUL_KD_DIFF: begin
            mul_a = $signed({1'b0, kd_ff});
            mul_b = MUL_B_W'(diff_ff);
         end
         MUL_KI_INTEG: begin
            mul_a = $signed({1'b0, ki_ff});
            mul_b = MUL_B_W'(integ_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // wheel value: base plus or minus the pid sum, shifted down toward zero
   assign base_ext = $signed(WHEEL_W'({base_ff, {SUM_SHIFT{1'b0}}}));
   assign acc_ext  = WHEEL_W'(acc_ff);
   assign wheel_x  = (ctrl.act == ACT_CLAMP_R) ? (base_ext - acc_ext) : (base_ext + acc_ext);
   assign wheel_r  = wheel_x[WHEEL_W-1] ? (wheel_x + WHEEL_W'((1 << SUM_SHIFT) - 1)) : wheel_x;
   assign wheel_v  = wheel_r >>> SUM_SHIFT;
   assign lim_ext  = $signed(WHEEL_W'(limit_ff));

   // times 1.2 toward zero on the clamped magnitude, then duty saturation
   assign scale_prod = wmag_ff * SCALE_W'(SCALE_MUL);
   assign scaled     = DRIVE_W'(scale_prod >> SCALE_SHIFT);
   assign duty       = (scaled > DRIVE_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : scaled[DUTY_W-1:0];

   assign err_mag     = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign recover_cnt = CNT_W'($countones(pattern_ff[SEARCH_HI:SEARCH_LO]));

   always_comb begin
      kp_in       = kp_ff;
      ki_in       = ki_ff;
      kd_in       = kd_ff;
      lost_in     = lost_ff;
      base_in     = base_ff;
      limit_in    = limit_ff;
      edge_th_in  = edge_th_ff;
      inner_th_in = inner_th_ff;
      pattern_in  = go ? hit : pattern_ff;
      tcnt_in     = tcnt_ff;
      neg_in      = neg_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      div_cnt_in  = div_cnt_ff;
      err_in      = err_ff;
      prev_in     = prev_ff;
      integ_in    = integ_ff;
      diff_in     = diff_ff;
      prod_in     = (ctrl.mul == MUL_NONE) ? prod_ff : PROD_W'(mul_a * mul_b);
      acc_in      = acc_ff;
      wmag_in     = wmag_ff;
      wneg_in     = wneg_ff;
      ldrive_in   = ldrive_ff;
      rdrive_in   = rdrive_ff;
      held_in     = held_ff;
      search_in   = search_ff;
      srch_out_in = srch_out_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_ldrive_in  = rsp_ldrive_ff;
      rsp_rdrive_in  = rsp_rdrive_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_pattern_in = rsp_pattern_ff;
      rsp_srch_in    = rsp_srch_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_KP:       kp_in       = csr_data[GAIN_W-1:0];
            REG_KI:       ki_in       = csr_data[GAIN_W-1:0];
            REG_KD:       kd_in       = csr_data[GAIN_W-1:0];
            REG_LOST:     lost_in     = csr_data[LIMIT_W-1:0];
            REG_BASE:     base_in     = csr_data[SPEED_W-1:0];
            REG_LIMIT:    limit_in    = csr_data[SPEED_W-1:0];
            REG_EDGE_TH:  edge_th_in  = csr_data[THRESH_W-1:0];
            REG_INNER_TH: inner_th_in = csr_data[THRESH_W-1:0];
            default: begin
            end
         endcase
      end

      case (ctrl.acc)
         ACC_CLEAR: acc_in = '0;
         ACC_ADD:   acc_in = acc_ff + ACC_W'(prod_ff);
         default: begin
         end
      endcase

      case (ctrl.act)
         ACT_SETUP: begin
            // dividend is |2W - 11T| scaled to the error's fraction
            tcnt_in    = t_cnt;
            neg_in     = n_neg;
            num_in     = DIV_W'({n_mag, {(FRAC_BITS - 1){1'b0}}});
            rem_in     = '0;
            div_cnt_in = CNT_W'(DIV_W);
         end
         ACT_DIV: begin
            if (r_try >= {1'b0, tcnt_ff}) begin
               rem_in = CNT_W'(r_try - {1'b0, tcnt_ff});
               num_in = {num_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = r_try[CNT_W-1:0];
               num_in = {num_ff[DIV_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - 1'b1;
         end
         ACT_ERR: begin
            // no line seen gives zero error
            if (tcnt_ff == '0) begin
               err_in = '0;
            end else if (neg_ff) begin
               err_in = ERR_W'(-$signed(num_ff));
            end else begin
               err_in = $signed(num_ff);
            end
         end
         ACT_INTEG: begin
            if (isum > (INTEG_W + 1)'(INTEG_MAX)) begin
               integ_in = INTEG_MAX;
            end else if (isum < (INTEG_W + 1)'(INTEG_MIN)) begin
               integ_in = INTEG_MIN;
            end else begin
               integ_in = isum[INTEG_W-1:0];
            end
            diff_in = $signed({err_ff[ERR_W-1], err_ff}) - $signed({prev_ff[ERR_W-1], prev_ff});
            prev_in = err_ff;
         end
         ACT_CLAMP_L, ACT_CLAMP_R: begin
            if (wheel_v > lim_ext) begin
               wmag_in = limit_ff;
               wneg_in = 1'b0;
            end else if (wheel_v < -lim_ext) begin
               wmag_in = limit_ff;
               wneg_in = (limit_ff != '0);
            end else begin
               wmag_in = wheel_v[WHEEL_W-1] ? DUTY_W'(-wheel_v) : DUTY_W'(wheel_v);
               wneg_in = wheel_v[WHEEL_W-1];
            end
         end
         ACT_SCALE_L: ldrive_in = {wneg_ff, duty};
         ACT_SCALE_R: rdrive_in = {wneg_ff, duty};
         ACT_LOST: begin
            // entering the hold: this frame's drive becomes the held drive
            if (err_mag >= {1'b0, lost_ff}) begin
               search_in   = 1'b1;
               held_in     = {rdrive_ff, ldrive_ff};
               srch_out_in = 1'b1;
            end else begin
               srch_out_in = 1'b0;
            end
         end
         ACT_SEARCH: begin
            // hold frame: repeat the held drive, leave pid state alone
            if (recover_cnt >= CNT_W'(RECOVER_COUNT)) begin
               search_in = 1'b0;
            end
            ldrive_in   = held_ff[DRIVE_W-1:0];
            rdrive_in   = held_ff[2*DRIVE_W-1:DRIVE_W];
            err_in      = '0;
            srch_out_in = 1'b1;
         end
         ACT_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_ldrive_in  = ldrive_ff;
               rsp_rdrive_in  = rdrive_ff;
               rsp_err_in     = err_ff;
               rsp_pattern_in = pattern_ff;
               rsp_srch_in    = srch_out_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= KP_RESET;
         ki_ff        <= KI_RESET;
         kd_ff        <= KD_RESET;
         lost_ff      <= LOST_RESET;
         base_ff      <= BASE_RESET;
         limit_ff     <= LIMIT_RESET;
         edge_th_ff   <= EDGE_RESET;
         inner_th_ff  <= INNER_RESET;
         prev_ff      <= '0;
         integ_ff     <= '0;
         search_ff    <= 1'b0;
         held_ff      <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         lost_ff      <= lost_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         edge_th_ff   <= edge_th_in;
         inner_th_ff  <= inner_th_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
         search_ff    <= search_in;
         held_ff      <= held_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and result payload
   always_ff @(posedge clock) begin
      pattern_ff     <= pattern_in;
      tcnt_ff        <= tcnt_in;
      neg_ff         <= neg_in;
      num_ff         <= num_in;
      rem_ff         <= rem_in;
      err_ff         <= err_in;
      diff_ff        <= diff_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      wmag_ff        <= wmag_in;
      wneg_ff        <= wneg_in;
      ldrive_ff      <= ldrive_in;
      rdrive_ff      <= rdrive_in;
      srch_out_ff    <= srch_out_in;
      rsp_ldrive_ff  <= rsp_ldrive_in;
      rsp_rdrive_ff  <= rsp_rdrive_in;
      rsp_err_ff     <= rsp_err_in;
      rsp_pattern_ff <= rsp_pattern_in;
      rsp_srch_ff    <= rsp_srch_in;
   end

`ifndef SYNTHESIS
   // a hold frame never disturbs the pid state
   a_search_keeps_pid: assert property (@(posedge clock) disable iff (reset)
      (ctrl.act == ACT_SEARCH) |=> ($stable(integ_ff) && $stable(prev_ff)))
      else $error("pid state changed during a hold frame");

   // the divided error stays inside the position range
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.act == ACT_INTEG) |-> (err_ff <= ERR_MAX && err_ff >= -ERR_MAX))
      else $error("line error out of range");

   // the divider leaves its loop after its last step
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (ctrl.act == ACT_DIV && div_cnt_ff == CNT_W'(1)) |=> (ctrl.act == ACT_ERR))
      else $error("divider loop did not exit");

   // a result beat only appears from the final program step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(ctrl.act) == ACT_FINISH))
      else $error("result beat raised outside the final step");
`endif

endmodule

@@ bench/lfpd_drive_check.sv @@
// result predictor and comparator for the line follower pid drive
// depends on lfpd_pkg; watches the request, result and register write channels
module lfpd_drive_check #(
   parameter int SAMPLE_W = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [SAMPLE_W-1:0]                  req_sample_0,
   input  logic [SAMPLE_W-1:0]                  req_sample_1,
   input  logic [SAMPLE_W-1:0]                  req_sample_2,
   input  logic [SAMPLE_W-1:0]                  req_sample_3,
   input  logic [SAMPLE_W-1:0]                  req_sample_4,
   input  logic [SAMPLE_W-1:0]                  req_sample_5,
   input  logic [SAMPLE_W-1:0]                  req_sample_6,
   input  logic [SAMPLE_W-1:0]                  req_sample_7,
   input  logic [SAMPLE_W-1:0]                  req_sample_8,
   input  logic [SAMPLE_W-1:0]                  req_sample_9,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [lfpd_pkg::DUTY_W-1:0]          rsp_left_duty,
   input  logic                                 rsp_left_reverse,
   input  logic [lfpd_pkg::DUTY_W-1:0]          rsp_right_duty,
   input  logic                                 rsp_right_reverse,
   input  logic signed [lfpd_pkg::ERR_W-1:0]    rsp_line_error,
   input  logic [lfpd_pkg::SENSOR_COUNT-1:0]    rsp_sensor_pattern,
   input  logic                                 rsp_searching,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [lfpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 end_check,
   output int                                   fail_count,
   output int                                   pending_count
);
   import lfpd_pkg::*;

   typedef struct packed {
      logic [DUTY_W-1:0]       left_duty;
      logic                    left_reverse;
      logic [DUTY_W-1:0]       right_duty;
      logic                    right_reverse;
      logic [ERR_W-1:0]        line_error;
      logic [SENSOR_COUNT-1:0] sensor_pattern;
      logic                    searching;
   } drive_cmd_type;

   // register copies
   logic [GAIN_W-1:0]   kp_gain, ki_gain, kd_gain;
   logic [LIMIT_W-1:0]  lost_limit;
   logic [SPEED_W-1:0]  base_speed, speed_limit;
   logic [THRESH_W-1:0] edge_threshold, inner_threshold;

   // controller state
   logic signed [ERR_W-1:0]   prev_error;
   logic signed [INTEG_W-1:0] integral_sum;
   logic                      holding;
   logic [DRIVE_W-1:0]        held_left, held_right;

   drive_cmd_type expected_drive[$];
   bit            leftover_checked;

   initial begin
      fail_count       = 0;
      pending_count    = 0;
      leftover_checked = 0;
   end

   task automatic note_mismatch(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic longint shift_toward_zero(input longint x);
      if (x < 0) begin
         return -((-x) >>> SUM_SHIFT);
      end
      return x >>> SUM_SHIFT;
   endfunction

   // clamp, scale by 1.2 toward zero, split into reverse bit and saturated duty
   function automatic logic [DRIVE_W-1:0] wheel_drive(input longint v);
      longint lim;
      longint mag;
      logic   rev;
      lim = longint'(speed_limit);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      v = (v * 6) / 5;
      rev = (v < 0);
      mag = rev ? -v : v;
      if (mag > DUTY_MAX) mag = DUTY_MAX;
      return {rev, mag[DUTY_W-1:0]};
   endfunction

   function automatic drive_cmd_type compute_drive(input logic [SENSOR_COUNT*SAMPLE_W-1:0] frame);
      drive_cmd_type           cmd;
      logic [SENSOR_COUNT-1:0] pattern;
      logic [SAMPLE_W-1:0]     s;
      logic [THRESH_W-1:0]     th;
      logic [DRIVE_W-1:0]      left_w, right_w;
      int                      i, weight_sum, hit_count, inner_hits;
      longint                  err, acc, pid_sum, base_scaled;
      pattern    = '0;
      weight_sum = 0;
      hit_count  = 0;
      inner_hits = 0;
      err        = 0;
      for (i = 0; i < SENSOR_COUNT; i++) begin
         s  = frame[i*SAMPLE_W +: SAMPLE_W];
         th = (i == 0 || i == SENSOR_COUNT - 1) ? edge_threshold : inner_threshold;
         if (s >= th) begin
            pattern[i] = 1'b1;
            weight_sum += i + 1;
            hit_count++;
         end
      end
      if (holding) begin
         // held frame: only look for the line coming back under the inner sensors
         for (i = SEARCH_LO; i <= SEARCH_HI; i++) begin
            if (pattern[i]) inner_hits++;
         end
         if (inner_hits >= RECOVER_COUNT) holding = 1'b0;
         left_w        = held_left;
         right_w       = held_right;
         cmd.searching = 1'b1;
      end else begin
         if (hit_count > 0) begin
            err = (longint'(2 * weight_sum - MID_WEIGHT * hit_count)
                   * (longint'(1) << (FRAC_BITS - 1))) / hit_count;
         end
         acc = longint'(integral_sum) + err;
         if (acc > longint'(INTEG_MAX)) acc = longint'(INTEG_MAX);
         if (acc < longint'(INTEG_MIN)) acc = longint'(INTEG_MIN);
         integral_sum = acc[INTEG_W-1:0];
         pid_sum = longint'(kp_gain) * err
                 + longint'(kd_gain) * (err - longint'(prev_error))
                 + longint'(ki_gain) * longint'(integral_sum);
         prev_error  = err[ERR_W-1:0];
         base_scaled = longint'(base_speed) <<< SUM_SHIFT;
         left_w  = wheel_drive(shift_toward_zero(base_scaled + pid_sum));
         right_w = wheel_drive(shift_toward_zero(base_scaled - pid_sum));
         if ((err < 0 ? -err : err) >= longint'(lost_limit)) begin
            holding    = 1'b1;
            held_left  = left_w;
            held_right = right_w;
         end
         cmd.searching = holding;
      end
      cmd.left_duty      = left_w[DUTY_W-1:0];
      cmd.left_reverse   = left_w[DUTY_W];
      cmd.right_duty     = right_w[DUTY_W-1:0];
      cmd.right_reverse  = right_w[DUTY_W];
      cmd.line_error     = err[ERR_W-1:0];
      cmd.sensor_pattern = pattern;
      return cmd;
   endfunction

   always @(posedge clock) begin : watch
      drive_cmd_type want;
      if (reset) begin
         kp_gain         = KP_RESET;
         ki_gain         = KI_RESET;
         kd_gain         = KD_RESET;
         lost_limit      = LOST_RESET;
         base_speed      = BASE_RESET;
         speed_limit     = LIMIT_RESET;
         edge_threshold  = EDGE_RESET;
         inner_threshold = INNER_RESET;
         prev_error      = '0;
         integral_sum    = '0;
         holding         = 1'b0;
         held_left       = '0;
         held_right      = '0;
         expected_drive.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_drive.size() == 0) begin
               note_mismatch("result beat with nothing expected");
            end else begin
               want = expected_drive.pop_front();
               if (rsp_left_duty !== want.left_duty)
                  note_mismatch($sformatf("left_duty got %0d want %0d",
                                          rsp_left_duty, want.left_duty));
               if (rsp_left_reverse !== want.left_reverse)
                  note_mismatch($sformatf("left_reverse got %0b want %0b",
                                          rsp_left_reverse, want.left_reverse));
               if (rsp_right_duty !== want.right_duty)
                  note_mismatch($sformatf("right_duty got %0d want %0d",
                                          rsp_right_duty, want.right_duty));
               if (rsp_right_reverse !== want.right_reverse)
                  note_mismatch($sformatf("right_reverse got %0b want %0b",
                                          rsp_right_reverse, want.right_reverse));
               if (rsp_line_error !== want.line_error)
                  note_mismatch($sformatf("line_error got %0d want %0d",
                                          rsp_line_error, $signed(want.line_error)));
               if (rsp_sensor_pattern !== want.sensor_pattern)
                  note_mismatch($sformatf("sensor_pattern got %b want %b",
                                          rsp_sensor_pattern, want.sensor_pattern));
               if (rsp_searching !== want.searching)
                  note_mismatch($sformatf("searching got %0b want %0b",
                                          rsp_searching, want.searching));
            end
         end
         if (req_valid && !req_stall) begin
            expected_drive.push_back(compute_drive({req_sample_9, req_sample_8, req_sample_7,
                                                    req_sample_6, req_sample_5, req_sample_4,
                                                    req_sample_3, req_sample_2, req_sample_1,
                                                    req_sample_0}));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_KP:       kp_gain         = csr_data[GAIN_W-1:0];
               REG_KI:       ki_gain         = csr_data[GAIN_W-1:0];
               REG_KD:       kd_gain         = csr_data[GAIN_W-1:0];
               REG_LOST:     lost_limit      = csr_data[LIMIT_W-1:0];
               REG_BASE:     base_speed      = csr_data[SPEED_W-1:0];
               REG_LIMIT:    speed_limit     = csr_data[SPEED_W-1:0];
               REG_EDGE_TH:  edge_threshold  = csr_data[THRESH_W-1:0];
               REG_INNER_TH: inner_threshold = csr_data[THRESH_W-1:0];
               default: ;
            endcase
         end
         if (end_check && !leftover_checked) begin
            leftover_checked = 1;
            if (expected_drive.size() != 0) begin
               note_mismatch($sformatf("%0d results never arrived", expected_drive.size()));
            end
         end
      end
      pending_count = expected_drive.size();
   end

endmodule

@@ bench/line_follow_pid_drive_unit_tb.sv @@
// stimulus and verdict for the line follower pid drive unit
// depends on lfpd_pkg, line_follow_pid_drive_unit and lfpd_drive_check
module line_follow_pid_drive_unit_tb;
   import lfpd_pkg::*;

   localparam int SAMPLE_W      = 12;
   localparam int SAMPLE_TOP    = (1 << SAMPLE_W) - 1;
   localparam int PACE_SPAN     = 25;   // frames per idling pattern
   localparam int SETTLE_CYCLES = 40;   // longer than a driving frame
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 4'd15;

   typedef logic [SENSOR_COUNT*SAMPLE_W-1:0] frame_type;

   // idling patterns, rotated every PACE_SPAN frames
   typedef enum int {
      PACE_FULL,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_type;

   typedef struct packed {
      int kp;
      int ki;
      int kd;
      int lost;
      int base;
      int limit;
      int edge_th;
      int inner_th;
   } drive_setting_type;

   logic clock;
   logic reset;

   logic                          req_valid;
   logic                          req_stall;
   logic [SAMPLE_W-1:0]           req_sample_0, req_sample_1, req_sample_2, req_sample_3;
   logic [SAMPLE_W-1:0]           req_sample_4, req_sample_5, req_sample_6, req_sample_7;
   logic [SAMPLE_W-1:0]           req_sample_8, req_sample_9;

   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [DUTY_W-1:0]             rsp_left_duty;
   logic                          rsp_left_reverse;
   logic [DUTY_W-1:0]             rsp_right_duty;
   logic                          rsp_right_reverse;
   logic signed [ERR_W-1:0]       rsp_line_error;
   logic [SENSOR_COUNT-1:0]       rsp_sensor_pattern;
   logic                          rsp_searching;

   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_data;

   logic                          end_check;
   int                            fail_count;
   int                            pending_count;

   int                sender_idle_pct;
   int                receiver_stall_pct;
   int                frames_sent;
   drive_setting_type setting;   // what the registers hold now, used to place samples

   line_follow_pid_drive_unit #(
      .SAMPLE_BITS (SAMPLE_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_0       (req_sample_0),
      .req_sample_1       (req_sample_1),
      .req_sample_2       (req_sample_2),
      .req_sample_3       (req_sample_3),
      .req_sample_4       (req_sample_4),
      .req_sample_5       (req_sample_5),
      .req_sample_6       (req_sample_6),
      .req_sample_7       (req_sample_7),
      .req_sample_8       (req_sample_8),
      .req_sample_9       (req_sample_9),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_duty      (rsp_left_duty),
      .rsp_left_reverse   (rsp_left_reverse),
      .rsp_right_duty     (rsp_right_duty),
      .rsp_right_reverse  (rsp_right_reverse),
      .rsp_line_error     (rsp_line_error),
      .rsp_sensor_pattern (rsp_sensor_pattern),
      .rsp_searching      (rsp_searching),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   lfpd_drive_check #(
      .SAMPLE_W (SAMPLE_W)
   ) drive_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_0       (req_sample_0),
      .req_sample_1       (req_sample_1),
      .req_sample_2       (req_sample_2),
      .req_sample_3       (req_sample_3),
      .req_sample_4       (req_sample_4),
      .req_sample_5       (req_sample_5),
      .req_sample_6       (req_sample_6),
      .req_sample_7       (req_sample_7),
      .req_sample_8       (req_sample_8),
      .req_sample_9       (req_sample_9),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_duty      (rsp_left_duty),
      .rsp_left_reverse   (rsp_left_reverse),
      .rsp_right_duty     (rsp_right_duty),
      .rsp_right_reverse  (rsp_right_reverse),
      .rsp_line_error     (rsp_line_error),
      .rsp_sensor_pattern (rsp_sensor_pattern),
      .rsp_searching      (rsp_searching),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .end_check          (end_check),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side back-pressure, redrawn every cycle at the falling edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // run limit: far beyond the slowest legal run of about 600 frames
   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic drive_setting_type make_setting(input int kp, input int ki, input int kd,
                                                      input int lost, input int base,
                                                      input int limit, input int edge_th,
                                                      input int inner_th);
      drive_setting_type s;
      s.kp       = kp;
      s.ki       = ki;
      s.kd       = kd;
      s.lost     = lost;
      s.base     = base;
      s.limit    = limit;
      s.edge_th  = edge_th;
      s.inner_th = inner_th;
      return s;
   endfunction

   // small gains most of the time so the correction does not always hit the clamp
   function automatic drive_setting_type random_setting();
      return make_setting(($urandom_range(1)) ? $urandom_range(127) : $urandom_range(1023),
                          ($urandom_range(1)) ? $urandom_range(31) : $urandom_range(1023),
                          ($urandom_range(1)) ? $urandom_range(127) : $urandom_range(1023),
                          $urandom_range(1152), $urandom_range(255), $urandom_range(255),
                          ($urandom_range(3) == 0) ? $urandom_range(SAMPLE_TOP)
                                                   : $urandom_range(3000, 100),
                          ($urandom_range(3) == 0) ? $urandom_range(SAMPLE_TOP)
                                                   : $urandom_range(3000, 100));
   endfunction

   // samples placed against the current thresholds so that on_bits is the pattern seen
   // unless a threshold is zero; tight puts every sample right at the threshold or one below it
   function automatic frame_type make_frame(input logic [SENSOR_COUNT-1:0] on_bits,
                                            input bit tight);
      frame_type f;
      int        i, th, v;
      for (i = 0; i < SENSOR_COUNT; i++) begin
         th = (i == 0 || i == SENSOR_COUNT - 1) ? setting.edge_th : setting.inner_th;
         if (on_bits[i] || th == 0) begin
            v = tight ? th : $urandom_range(SAMPLE_TOP, th);
         end else begin
            v = tight ? th - 1 : $urandom_range(th - 1, 0);
         end
         f[i*SAMPLE_W +: SAMPLE_W] = v[SAMPLE_W-1:0];
      end
      return f;
   endfunction

   function automatic frame_type random_frame();
      frame_type               f;
      logic [SENSOR_COUNT-1:0] bits;
      int                      r, w, start, i;
      r = $urandom_range(99);
      if (r < 45) begin
         // a line one to three sensors wide somewhere under the bar
         w     = $urandom_range(3, 1);
         start = $urandom_range(SENSOR_COUNT - w, 0);
         bits  = '0;
         for (i = start; i < start + w; i++) bits[i] = 1'b1;
         f = make_frame(bits, 1'b0);
      end else if (r < 60) begin
         f = make_frame(SENSOR_COUNT'($urandom_range(1023)), 1'b0);
      end else if (r < 68) begin
         f = make_frame('0, 1'b0);
      end else if (r < 76) begin
         f = make_frame(SENSOR_COUNT'($urandom_range(1023)), 1'b1);
      end else begin
         // raw noise, every sample bit free
         for (i = 0; i < SENSOR_COUNT; i++) begin
            f[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(SAMPLE_TOP));
         end
      end
      return f;
   endfunction

   // one request beat; valid stays up into the next call unless an idle gap is drawn
   task automatic send_frame(input frame_type f);
      if (frames_sent % PACE_SPAN == 0) begin
         case (pace_type'((frames_sent / PACE_SPAN) % 4))
            PACE_FULL:           begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            PACE_SENDER_IDLE:    begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
            PACE_RECEIVER_STALL: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
            default:             begin sender_idle_pct = 14; receiver_stall_pct = 14; end
         endcase
      end
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_0 <= f[0*SAMPLE_W +: SAMPLE_W];
      req_sample_1 <= f[1*SAMPLE_W +: SAMPLE_W];
      req_sample_2 <= f[2*SAMPLE_W +: SAMPLE_W];
      req_sample_3 <= f[3*SAMPLE_W +: SAMPLE_W];
      req_sample_4 <= f[4*SAMPLE_W +: SAMPLE_W];
      req_sample_5 <= f[5*SAMPLE_W +: SAMPLE_W];
      req_sample_6 <= f[6*SAMPLE_W +: SAMPLE_W];
      req_sample_7 <= f[7*SAMPLE_W +: SAMPLE_W];
      req_sample_8 <= f[8*SAMPLE_W +: SAMPLE_W];
      req_sample_9 <= f[9*SAMPLE_W +: SAMPLE_W];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames_sent++;
   endtask

   // drop valid and let every outstanding result come back, then let the unit settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // valid is left high; apply_setting lowers it after the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_setting(input drive_setting_type s);
      setting = s;
      write_reg(REG_KP, s.kp);
      write_reg(REG_KI, s.ki);
      write_reg(REG_KD, s.kd);
      write_reg(REG_LOST, s.lost);
      write_reg(REG_BASE, s.base);
      write_reg(REG_LIMIT, s.limit);
      write_reg(REG_EDGE_TH, s.edge_th);
      write_reg(REG_INNER_TH, s.inner_th);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // line drifts off one side until it is lost, then comes back under the middle
   task automatic sweep();
      logic [SENSOR_COUNT-1:0] p, q;
      bit                      mirror;
      int                      k, j;
      mirror = $urandom_range(1);
      for (k = 0; k < 10; k++) begin
         case (k)
            0:       p = 10'b0000110000;
            1:       p = 10'b0001100000;
            2:       p = 10'b0011000000;
            3:       p = 10'b0110000000;
            4:       p = 10'b1100000000;
            5:       p = 10'b1000000000;
            6, 7:    p = 10'b0000000000;
            8:       p = 10'b0011000000;
            default: p = 10'b0000110000;
         endcase
         for (j = 0; j < SENSOR_COUNT; j++) q[j] = p[SENSOR_COUNT-1-j];
         send_frame(make_frame(mirror ? q : p, 1'b0));
      end
   endtask

   task automatic run_random(input int count);
      int k;
      k = 0;
      while (k < count) begin
         if ($urandom_range(24) == 0) begin
            sweep();
            k += 10;
         end else begin
            send_frame(random_frame());
            k++;
         end
         // now and then hold off until the unit has answered everything
         if ($urandom_range(59) == 0) wait_drained();
      end
   endtask

   initial begin : stimulus
      int k;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_sample_0       = '0;
      req_sample_1       = '0;
      req_sample_2       = '0;
      req_sample_3       = '0;
      req_sample_4       = '0;
      req_sample_5       = '0;
      req_sample_6       = '0;
      req_sample_7       = '0;
      req_sample_8       = '0;
      req_sample_9       = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      end_check          = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      frames_sent        = 0;
      setting = make_setting(KP_RESET, KI_RESET, KD_RESET, LOST_RESET, BASE_RESET,
                             LIMIT_RESET, EDGE_RESET, INNER_RESET);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames on the reset register values
      send_frame('0);                                      // no line anywhere
      send_frame({SENSOR_COUNT{SAMPLE_W'(SAMPLE_TOP)}});  // full-scale on every sensor
      send_frame(make_frame('0, 1'b1));                    // all one below threshold
      send_frame(make_frame(10'b0000000001, 1'b1));        // edge sensor at threshold, lost
      send_frame(make_frame('0, 1'b0));                    // held, nothing seen
      send_frame(make_frame(10'b1100010011, 1'b0));        // held, one inner sensor only
      send_frame(make_frame(10'b0010000100, 1'b1));        // two inner sensors recover
      send_frame(make_frame(10'b0000010000, 1'b1));        // inner sensor at threshold
      send_frame(make_frame(10'b0000001011, 1'b0));        // division truncates, negative
      send_frame(make_frame(10'b1101000000, 1'b0));        // division truncates, positive
      send_frame(make_frame(10'b0000110000, 1'b0));        // centered
      send_frame(make_frame(10'b1100000000, 1'b0));        // far right enters the hold
      send_frame(make_frame(10'b0000001100, 1'b0));        // recover
      send_frame(make_frame(10'b1000000000, 1'b0));        // largest error
      send_frame({SENSOR_COUNT{SAMPLE_W'(SAMPLE_TOP)}});  // recover with every sensor
      for (k = 0; k < 6; k++) send_frame(random_frame());

      // register settings, each applied with nothing in flight
      wait_drained();
      write_reg(CSR_SPARE_INDEX, $urandom_range(SAMPLE_TOP));  // unmapped index is ignored
      apply_setting(random_setting());
      run_random(110);

      wait_drained();
      apply_setting(make_setting(1023, 1023, 1023, 1152, 255, 255, SAMPLE_TOP, SAMPLE_TOP));
      run_random(40);

      // zero limit and zero thresholds: every driving frame enters the hold
      wait_drained();
      apply_setting(make_setting(0, 0, 0, 0, 0, 0, 0, 0));
      run_random(30);

      wait_drained();
      apply_setting(random_setting());
      run_random(110);

      // long one-sided runs push the integral into both saturation limits
      wait_drained();
      apply_setting(make_setting(4, 1023, 0, 1152, 128, 255, 2048, 2048));
      for (k = 0; k < 36; k++) send_frame(make_frame(10'b1100000000, 1'b0));
      for (k = 0; k < 70; k++) send_frame(make_frame(10'b0000000011, 1'b0));
      run_random(20);

      wait_drained();
      apply_setting(random_setting());
      run_random(110);

      // drain, then have the checker flag anything still owed
      wait_drained();
      @(negedge clock);
      end_check <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/lfpd_pkg.sv
sv/lfpd_seq.sv
sv/line_follow_pid_drive_unit.sv
bench/lfpd_drive_check.sv
bench/line_follow_pid_drive_unit_tb.sv
